[design/cpmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmp_pkg
// Shared types, constants and character classes for the channel/payload
// message parser.
// ----------------------------------------------------------------------------
package cpmp_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NAME_SLOTS  = 8;
  localparam int unsigned NAME_W      = CHAR_W * NAME_SLOTS;
  localparam int unsigned NAME_LEN_W  = 4;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PLEN_W      = 8;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;

  localparam logic [CHAR_W-1:0] RST_CHANNEL_START = 8'd60;
  localparam logic [CHAR_W-1:0] RST_CHANNEL_END   = 8'd62;
  localparam logic [CHAR_W-1:0] RST_PAYLOAD_START = 8'd40;
  localparam logic [CHAR_W-1:0] RST_PAYLOAD_END   = 8'd41;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_START = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_END   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_START = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_END   = 8'd3;

  // Control handed from the parser to the payload accumulator.
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [CHAR_W-1:0] data;
  } acc_ctrl_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) ||
           ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
           ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z));
  endfunction

endpackage

[design/cpmp_name_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmp_name_cell
// One character slot of the name buffer. A write token travels along the
// row of cells; the cell holding it takes the next stored character.
// ----------------------------------------------------------------------------
module cpmp_name_cell
  import cpmp_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              store,
  input  logic              token_in,
  input  logic [CHAR_W-1:0] char_in,
  output logic              token,
  output logic [CHAR_W-1:0] char_q
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      token  <= FIRST;
      char_q <= '0;
    end else if (store) begin
      token <= token_in;
      if (token) begin
        char_q <= char_in;
      end
    end
  end

endmodule

[design/cpmp_payload_acc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmp_payload_acc
// Running decimal accumulator for the payload: magnitude, sign and a
// saturating character count.
// ----------------------------------------------------------------------------
module cpmp_payload_acc
  import cpmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  acc_ctrl_t          ctrl,
  output logic [VALUE_W-1:0] value,
  output logic [PLEN_W-1:0]  length
);

  logic [VALUE_W-1:0] magnitude;
  logic               negative;
  logic               first;
  logic [VALUE_W-1:0] magnitude_next;
  logic [PLEN_W-1:0]  length_next;

  // Multiply by ten as two shifts and an add, modulo 2^32.
  assign magnitude_next = (magnitude << 3) + (magnitude << 1)
                        + VALUE_W'(ctrl.data - CHAR_ZERO);
  assign length_next    = (length == {PLEN_W{1'b1}}) ? length : length + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude <= '0;
      negative  <= 1'b0;
      first     <= 1'b0;
      length    <= '0;
    end else if (ctrl.clear) begin
      magnitude <= '0;
      negative  <= 1'b0;
      first     <= 1'b1;
      length    <= '0;
    end else if (ctrl.step) begin
      if (ctrl.data == CHAR_MINUS && first) begin
        negative <= 1'b1;
        length   <= length_next;
      end else if (is_digit(ctrl.data)) begin
        magnitude <= magnitude_next;
        length    <= length_next;
      end
      first <= 1'b0;
    end
  end

  assign value = negative ? (VALUE_W'(0) - magnitude) : magnitude;

endmodule

[design/channel_payload_message_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_payload_message_parser
// Parses <name>(value) style messages from a received byte stream.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while rx_stall is low: the phase
// decode, the name write and the multiply-by-ten add all settle within the
// cycle in which the byte is taken. The name is held in a row of character
// cells through which a write token moves; the payload value builds up in an
// accumulator. When the payload-end byte is taken, the complete request
// appears in the output register on the next cycle. The byte input stalls
// only while a payload-end byte is offered and the previous request is still
// held in the output register under stall.
module channel_payload_message_parser
  import cpmp_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  output logic                      rx_stall,
  input  logic [CHAR_W-1:0]         rx_byte,
  output logic                      msg_valid,
  input  logic                      msg_stall,
  output logic [NAME_W-1:0]         channel_name,
  output logic [NAME_LEN_W-1:0]     channel_length,
  output logic signed [VALUE_W-1:0] payload_value,
  output logic [PLEN_W-1:0]         payload_length,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CHAR_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {
    AWAIT_CHANNEL,
    IN_NAME,
    AWAIT_PAYLOAD,
    IN_PAYLOAD
  } phase_t;

  phase_t              phase;
  logic [CHAR_W-1:0]   channel_start_char;
  logic [CHAR_W-1:0]   channel_end_char;
  logic [CHAR_W-1:0]   payload_start_char;
  logic [CHAR_W-1:0]   payload_end_char;
  logic [NAME_LEN_W-1:0] name_count;

  logic                accept;
  logic                emit;
  logic                name_clear;
  logic                name_store;
  acc_ctrl_t           acc_ctrl;
  logic [VALUE_W-1:0]  acc_value;
  logic [PLEN_W-1:0]   acc_length;
  logic [NAME_W-1:0]   name_bus;
  logic [MAX_NAME_LEN:0] token_chain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_start_char <= RST_CHANNEL_START;
      channel_end_char   <= RST_CHANNEL_END;
      payload_start_char <= RST_PAYLOAD_START;
      payload_end_char   <= RST_PAYLOAD_END;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNEL_START: channel_start_char <= cfg_data;
        REG_CHANNEL_END:   channel_end_char   <= cfg_data;
        REG_PAYLOAD_START: payload_start_char <= cfg_data;
        REG_PAYLOAD_END:   payload_end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a byte that completes a request waits on a full output register.
  assign rx_stall = rx_valid && msg_valid && msg_stall &&
                    (phase == IN_PAYLOAD) && (rx_byte == payload_end_char);
  assign accept   = rx_valid && !rx_stall;
  assign emit     = accept && (phase == IN_PAYLOAD) && (rx_byte == payload_end_char);

  assign name_clear = accept && (rx_byte == channel_start_char) &&
                      ((phase == AWAIT_CHANNEL) ||
                       ((phase == IN_NAME) && (rx_byte != channel_end_char)));
  assign name_store = accept && (phase == IN_NAME) &&
                      (rx_byte != channel_end_char) &&
                      (rx_byte != channel_start_char) &&
                      is_alnum(rx_byte) &&
                      (name_count < NAME_LEN_W'(MAX_NAME_LEN));

  assign acc_ctrl.clear = accept && (phase == AWAIT_PAYLOAD) &&
                          (rx_byte == payload_start_char);
  assign acc_ctrl.step  = accept && (phase == IN_PAYLOAD) &&
                          (rx_byte != payload_end_char);
  assign acc_ctrl.data  = rx_byte;

  assign token_chain[0] = 1'b0;

  for (genvar i = 0; i < NAME_SLOTS; i++) begin : g_slot
    if (i < MAX_NAME_LEN) begin : g_cell
      cpmp_name_cell #(
        .FIRST (i == 0)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (name_clear),
        .store    (name_store),
        .token_in (token_chain[i]),
        .char_in  (rx_byte),
        .token    (token_chain[i+1]),
        .char_q   (name_bus[CHAR_W*i +: CHAR_W])
      );
    end else begin : g_pad
      assign name_bus[CHAR_W*i +: CHAR_W] = '0;
    end
  end

  cpmp_payload_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .value  (acc_value),
    .length (acc_length)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= AWAIT_CHANNEL;
      name_count <= '0;
      msg_valid  <= 1'b0;
    end else begin
      if (emit) begin
        msg_valid      <= 1'b1;
        channel_name   <= name_bus;
        channel_length <= name_count;
        payload_value  <= acc_value;
        payload_length <= acc_length;
      end else if (!msg_stall) begin
        msg_valid <= 1'b0;
      end

      if (name_clear) begin
        name_count <= '0;
      end else if (name_store) begin
        name_count <= name_count + 1'b1;
      end

      if (accept) begin
        unique case (phase)
          AWAIT_CHANNEL: begin
            if (rx_byte == channel_start_char) begin
              phase <= IN_NAME;
            end
          end
          IN_NAME: begin
            if (rx_byte == channel_end_char) begin
              phase <= AWAIT_PAYLOAD;
            end
          end
          AWAIT_PAYLOAD: begin
            if (rx_byte == payload_start_char) begin
              phase <= IN_PAYLOAD;
            end
          end
          IN_PAYLOAD: begin
            if (rx_byte == payload_end_char) begin
              phase <= AWAIT_CHANNEL;
            end
          end
          default: phase <= AWAIT_CHANNEL;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == AWAIT_CHANNEL) && msg_valid)
    else $error("request not issued or parser not back to channel wait");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_LEN_W'(MAX_NAME_LEN))
    else $error("name count beyond limit");

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(token_chain))
    else $error("more than one write token in name cells");

  a_token_matches_count: assert property (@(posedge clk) disable iff (rst)
    (name_count < NAME_LEN_W'(MAX_NAME_LEN)) |-> $onehot(token_chain))
    else $error("write token lost while name has room");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> msg_valid && msg_stall && (phase == IN_PAYLOAD))
    else $error("byte input stalled without a held request");
`endif

endmodule
